/* rtl/afg_pkg.sv */
// Shared types and constants for the audio fade gain ramp unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package afg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int RAMP_BITS   = 20;
    localparam int OP_BITS     = 2;
    localparam int PHASE_BITS  = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;

    localparam logic [RAMP_BITS-1:0] RAMP_RESET = RAMP_BITS'(480);

    // operation codes
    localparam logic [OP_BITS-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FADE_OUT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FADE_IN  = 2'd2;

    // phase codes
    localparam logic [PHASE_BITS-1:0] PH_ACTIVE   = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_FADE_OUT = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_FADE_IN  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 1'b1;

    typedef struct packed {
        logic [OP_BITS-1:0]            operation;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } afg_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [PHASE_BITS-1:0]         phase_now;
        logic                          fade_out_done;
    } afg_out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;  // request taken this cycle
        logic load;    // write the result register
    } afg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // accepted request starts a step division
        logic div_done;  // step division finished
    } afg_stat_t;

endpackage

`default_nettype wire

/* rtl/afg_div.sv */
// Restoring divider, one quotient bit per cycle, for the ramp step size.
// Depends on afg_pkg (RAMP_BITS).
`timescale 1ns / 1ps
`default_nettype none

module afg_div import afg_pkg::*; #(
    parameter int DIVIDEND_BITS = 17
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [RAMP_BITS-1:0]     divisor,
    output logic                          busy,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CW = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [RAMP_BITS-1:0]     rem_reg, rem_next;
    logic [RAMP_BITS-1:0]     den_reg, den_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [RAMP_BITS:0]       trial;
    logic [RAMP_BITS:0]       diff;
    logic                     qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        // shift in next dividend bit; remainder stays below divisor
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIVIDEND_BITS - 1);
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], qbit};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/afg_dp.sv */
// Datapath: config registers, gain state, step divider and sample multiply.
// Depends on afg_pkg and afg_div.
`timescale 1ns / 1ps
`default_nettype none

module afg_dp import afg_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire afg_in_t               s_data,
    input  wire afg_cmd_t              cmd,
    output afg_stat_t                  stat,
    output afg_out_t                   m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int PW = SAMPLE_BITS + GW + 1;
    localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

    logic [RAMP_BITS-1:0]          ramp_steps_reg, ramp_steps_next;
    logic                          enabled_reg, enabled_next;
    logic [GW-1:0]                 gain_level_reg, gain_level_next;
    logic [GW-1:0]                 gain_target_reg, gain_target_next;
    logic signed [GW:0]            gain_step_reg, gain_step_next;
    logic [RAMP_BITS-1:0]          steps_left_reg, steps_left_next;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic                          silence_reg, silence_next;
    logic                          neg_reg, neg_next;
    logic [OP_BITS-1:0]            item_op_reg, item_op_next;
    logic signed [SAMPLE_BITS-1:0] item_sample_reg, item_sample_next;
    logic                          item_pass_reg, item_pass_next;
    afg_out_t                      out_reg, out_next;

    logic [GW+1:0]                 lvl_sum;
    logic [GW-1:0]                 tgt;
    logic                          retarget_go;
    logic                          need_div;
    logic [GW-1:0]                 dividend;
    logic                          div_busy;
    logic                          div_done;
    logic [GW-1:0]                 div_q;
    logic signed [PW-1:0]          samp_ext;
    logic signed [PW-1:0]          gain_ext;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          prod_sh;

    afg_div #(
        .DIVIDEND_BITS (GW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (need_div),
        .dividend (dividend),
        .divisor  (ramp_steps_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // floor(sample * gain / 2^frac) by arithmetic shift
    assign samp_ext = {{(GW+1){item_sample_reg[SAMPLE_BITS-1]}}, item_sample_reg};
    assign gain_ext = {{(SAMPLE_BITS+1){1'b0}}, gain_level_reg};
    assign prod     = samp_ext * gain_ext;
    assign prod_sh  = prod >>> GAIN_FRAC_BITS;

    always_comb begin
        ramp_steps_next  = ramp_steps_reg;
        enabled_next     = enabled_reg;
        gain_level_next  = gain_level_reg;
        gain_target_next = gain_target_reg;
        gain_step_next   = gain_step_reg;
        steps_left_next  = steps_left_reg;
        phase_next       = phase_reg;
        silence_next     = silence_reg;
        neg_next         = neg_reg;
        item_op_next     = item_op_reg;
        item_sample_next = item_sample_reg;
        item_pass_next   = item_pass_reg;
        out_next         = out_reg;
        retarget_go      = 1'b0;
        need_div         = 1'b0;

        lvl_sum = {2'b00, gain_level_reg} + {gain_step_reg[GW], gain_step_reg};
        tgt     = (s_data.operation == OP_FADE_IN) ? UNITY : '0;
        dividend = (tgt == '0) ? gain_level_reg : (UNITY - gain_level_reg);

        if (cmd.accept) begin
            item_op_next     = s_data.operation;
            item_sample_next = s_data.sample_in;
            item_pass_next   = !enabled_reg;
            unique case (s_data.operation)
                OP_SAMPLE: begin
                    if (enabled_reg) begin
                        if (steps_left_reg != '0) begin
                            steps_left_next = steps_left_reg - 1'b1;
                            gain_level_next = (steps_left_reg == RAMP_BITS'(1)) ?
                                              gain_target_reg : lvl_sum[GW-1:0];
                        end
                        if (phase_reg == PH_FADE_OUT && gain_level_next == '0) begin
                            silence_next = 1'b1;
                        end
                        if (phase_reg == PH_FADE_IN && steps_left_next == '0) begin
                            phase_next = PH_ACTIVE;
                        end
                    end
                end
                OP_FADE_OUT: begin
                    silence_next = 1'b0;
                    if (phase_reg != PH_FADE_OUT) begin
                        phase_next  = PH_FADE_OUT;
                        retarget_go = 1'b1;
                    end
                end
                OP_FADE_IN: begin
                    if (phase_reg != PH_FADE_IN) begin
                        phase_next  = PH_FADE_IN;
                        retarget_go = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // retarget; same target leaves the ramp alone
        if (retarget_go && tgt != gain_target_reg) begin
            gain_target_next = tgt;
            if (ramp_steps_reg == '0) begin
                gain_level_next = tgt;
                gain_step_next  = '0;
                steps_left_next = '0;
            end else begin
                steps_left_next = ramp_steps_reg;
                neg_next        = (tgt == '0);
                need_div        = 1'b1;
            end
        end

        if (div_done) begin
            gain_step_next = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        end

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_RAMP_STEPS: ramp_steps_next = cfg_data[RAMP_BITS-1:0];
                CFG_ENABLED: begin
                    enabled_next = cfg_data[0];
                    if (cfg_data[0]) begin
                        gain_level_next  = UNITY;
                        gain_target_next = UNITY;
                        gain_step_next   = '0;
                        steps_left_next  = '0;
                        phase_next       = PH_ACTIVE;
                        silence_next     = 1'b0;
                    end
                end
            endcase
        end

        if (cmd.load) begin
            out_next.phase_now     = phase_reg;
            out_next.fade_out_done = silence_reg;
            if (item_op_reg != OP_SAMPLE) begin
                out_next.sample_out = '0;
            end else if (item_pass_reg) begin
                out_next.sample_out = item_sample_reg;
            end else begin
                out_next.sample_out = prod_sh[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_steps_reg  <= RAMP_RESET;
            enabled_reg     <= 1'b1;
            gain_level_reg  <= UNITY;
            gain_target_reg <= UNITY;
            gain_step_reg   <= '0;
            steps_left_reg  <= '0;
            phase_reg       <= PH_ACTIVE;
            silence_reg     <= 1'b0;
        end else begin
            ramp_steps_reg  <= ramp_steps_next;
            enabled_reg     <= enabled_next;
            gain_level_reg  <= gain_level_next;
            gain_target_reg <= gain_target_next;
            gain_step_reg   <= gain_step_next;
            steps_left_reg  <= steps_left_next;
            phase_reg       <= phase_next;
            silence_reg     <= silence_next;
        end
        neg_reg         <= neg_next;
        item_op_reg     <= item_op_next;
        item_sample_reg <= item_sample_next;
        item_pass_reg   <= item_pass_next;
        out_reg         <= out_next;
    end

    assign stat.need_div = need_div;
    assign stat.div_done = div_done;
    assign m_data        = out_reg;

    // gain never leaves [0, unity]
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_level_reg <= UNITY)
        else $error("gain above unity");

    // target is always silence or unity
    a_target_code: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_target_reg == '0 || gain_target_reg == UNITY)
        else $error("gain target not 0 or unity");

    // no request taken while a step division is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !div_busy)
        else $error("request accepted during division");

    // a just-started step division does not signal done right away
    a_done_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        need_div |=> !div_done)
        else $error("division finished too early");

endmodule

`default_nettype wire

/* rtl/afg_ctrl.sv */
// Controller FSM: request handshake, wait on division, result register load.
// Depends on afg_pkg (command and status structs).
`timescale 1ns / 1ps
`default_nettype none

module afg_ctrl import afg_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire afg_stat_t stat,
    output afg_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.accept   = 1'b0;
        cmd.load     = 1'b0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // a finished division is only seen in the wait state, which moves on to the result load
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> state_reg == ST_DIV)
        else $error("division done outside wait state");

    // a result load raises valid; loads happen only when no untaken result is held
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid_reg)
        else $error("load did not raise valid");

endmodule

`default_nettype wire

/* rtl/audio_fade_out_in_gain_ramp_unit.sv */
// Top level of the audio fade gain ramp unit.
// Depends on afg_pkg, afg_ctrl, afg_dp (which holds afg_div).
//
// Sequence: a request is accepted in IDLE; an audio sample is then multiplied
// and loaded into the result register in OUT once that register is free; a
// fade request that starts a ramp first waits in DIV for the step divider
// (one quotient bit per cycle). A new request is taken only back in IDLE.
// Reset (aresetn, synchronous, low): unity gain, active phase, ramp 480,
// fader enabled, no result pending; ready straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module audio_fade_out_in_gain_ramp_unit import afg_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire afg_in_t               s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output afg_out_t                   m_data,
    // config write port: index 0 ramp_steps, index 1 enabled
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    afg_cmd_t  cmd;
    afg_stat_t stat;

    // FSM: IDLE takes a request, DIV waits for the step quotient,
    // OUT loads the result register once it is free
    afg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // gain state updates at the accept edge; multiply happens on load
    afg_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

/* tb/tb_audio_fade_out_in_gain_ramp_unit.sv */
// Self-checking testbench for the audio fade gain ramp unit: directed and random requests,
// predicted results compared field by field. Depends on afg_pkg and the unit's top level.
`timescale 1ns / 1ps

module tb_audio_fade_out_in_gain_ramp_unit;
    import afg_pkg::*;

    localparam int              GAIN_FRAC = 16;
    localparam logic [16:0]     UNITY     = 17'h10000;
    // operation code that the unit must ignore
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
    localparam logic [CFG_DATA_W-1:0] RAMP_MAX = 20'hFFFFF;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    afg_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    afg_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    audio_fade_out_in_gain_ramp_unit #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Fader predictor: own copy of the gain ramp state and the registers.
    // ------------------------------------------------------------------
    logic [RAMP_BITS-1:0]   ramp_len_reg;
    logic                   fader_enabled;
    logic [16:0]            gain_now;
    logic [16:0]            gain_goal;
    logic signed [17:0]     gain_delta;
    logic [RAMP_BITS-1:0]   ramp_remaining;
    logic [PHASE_BITS-1:0]  fade_state;
    logic                   silence_seen;

    afg_in_t  request_queue[$];      // requests waiting for the driver
    afg_out_t predicted_results[$];  // expected results, oldest first

    int  error_count  = 0;
    int  items_queued = 0;
    bit  idle_on      = 1'b1;        // random idling on both channels

    function automatic void fader_prepare();
        gain_now       = UNITY;
        gain_goal      = UNITY;
        gain_delta     = '0;
        ramp_remaining = '0;
        fade_state     = PH_ACTIVE;
        silence_seen   = 1'b0;
    endfunction

    // New target from the current gain; no-op if the target is unchanged.
    function automatic void retarget_gain(logic [16:0] goal);
        if (goal == gain_goal)
            return;
        gain_goal = goal;
        if (ramp_len_reg == 0) begin
            // zero-length ramp jumps straight to the target
            gain_now       = goal;
            gain_delta     = '0;
            ramp_remaining = '0;
        end else begin
            // signed division truncates toward zero
            gain_delta     = 18'((longint'(goal) - longint'(gain_now))
                                 / longint'(ramp_len_reg));
            ramp_remaining = ramp_len_reg;
        end
    endfunction

    function automatic afg_out_t fader_predict(afg_in_t req);
        afg_out_t res;
        longint   prod;
        res = '0;
        case (req.operation)
            OP_SAMPLE: begin
                if (!fader_enabled) begin
                    res.sample_out = req.sample_in;
                end else begin
                    if (ramp_remaining != 0) begin
                        ramp_remaining = ramp_remaining - 1'b1;
                        if (ramp_remaining == 0)
                            gain_now = gain_goal;   // last step lands on target
                        else
                            gain_now = 17'(longint'(gain_now) + longint'(gain_delta));
                    end
                    prod = longint'($signed(req.sample_in)) * longint'(gain_now);
                    res.sample_out = SAMPLE_BITS'(prod >>> GAIN_FRAC);  // floor
                    if (fade_state == PH_FADE_OUT && gain_now == 0)
                        silence_seen = 1'b1;
                    if (fade_state == PH_FADE_IN && ramp_remaining == 0)
                        fade_state = PH_ACTIVE;
                end
            end
            OP_FADE_OUT: begin
                // a repeated fade-out only clears the flag
                silence_seen = 1'b0;
                if (fade_state != PH_FADE_OUT) begin
                    fade_state = PH_FADE_OUT;
                    retarget_gain('0);
                end
            end
            OP_FADE_IN: begin
                if (fade_state != PH_FADE_IN) begin
                    fade_state = PH_FADE_IN;
                    retarget_gain(UNITY);
                end
            end
            default: ;
        endcase
        res.phase_now     = fade_state;
        res.fade_out_done = silence_seen;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: pulls from request_queue, idles in random bursts.
    // Prediction is made at the edge where the request is accepted.
    // ------------------------------------------------------------------
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                predicted_results.push_back(fader_predict(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 18) - 1;
                    s_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= request_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted result, stalls in bursts.
    // ------------------------------------------------------------------
    int unsigned stall_left;
    afg_out_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result, sample_out",
                                    longint'($signed(m_data.sample_out)), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_data.sample_out !== want.sample_out)
                        report_mismatch("sample_out", longint'($signed(m_data.sample_out)),
                                        longint'($signed(want.sample_out)));
                    if (m_data.phase_now !== want.phase_now)
                        report_mismatch("phase_now", m_data.phase_now, want.phase_now);
                    if (m_data.fade_out_done !== want.fade_out_done)
                        report_mismatch("fade_out_done", m_data.fade_out_done,
                                        want.fade_out_done);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [OP_BITS-1:0] op, logic signed [SAMPLE_BITS-1:0] smp);
        afg_in_t req;
        req.operation = op;
        req.sample_in = smp;
        request_queue.push_back(req);
        if (op != OP_UNUSED)
            items_queued++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_BITS'($signed($urandom_range(0, 600)) - 300);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // A run of samples: for ramps up to 40 usually long enough to finish the ramp, sometimes
    // cut short so the next request retargets mid-ramp; longer ramps are always cut short. Some noise mixed in.
    task automatic queue_samples(int unsigned ramp);
        int unsigned n;
        logic [OP_BITS-1:0] noise_ops[4];
        noise_ops = '{OP_SAMPLE, OP_FADE_OUT, OP_FADE_IN, OP_UNUSED};
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, (ramp > 40) ? 40 : ramp);
        else if (ramp <= 40)
            n = ramp + $urandom_range(0, 3);
        else
            n = $urandom_range(10, 40);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0)
                push_req(noise_ops[$urandom_range(0, 3)], rand_sample());
            else
                push_req(OP_SAMPLE, rand_sample());
        end
    endtask

    task automatic queue_fade_cycle(int unsigned ramp);
        push_req(OP_FADE_OUT, rand_sample());
        if ($urandom_range(0, 3) == 0)
            push_req(OP_FADE_OUT, rand_sample());
        queue_samples(ramp);
        push_req(OP_FADE_IN, rand_sample());
        if ($urandom_range(0, 3) == 0)
            push_req(OP_FADE_IN, rand_sample());
        queue_samples(ramp);
    endtask

    // Wait until every queued request is in and every result is back, then
    // cover the slow fade-request latency before touching the registers.
    // Checked at the falling edge so the rising-edge updates have settled.
    task automatic drain();
        while (request_queue.size() != 0 || s_valid || predicted_results.size() != 0)
            @(negedge aclk);
        repeat (GAIN_FRAC + 8) @(posedge aclk);
    endtask

    // Register write; the predictor follows at the edge that performs it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RAMP_STEPS) begin
            ramp_len_reg = val;
        end else begin
            fader_enabled = val[0];
            if (val[0])
                fader_prepare();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned ramp;
        int          start_cnt;
        bit          paused;
        bit          was_off;

        ramp_len_reg  = RAMP_RESET;
        fader_enabled = 1'b1;
        fader_prepare();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // unity gain at reset: extremes pass through, unused op ignored
        push_req(OP_SAMPLE, S_MAX);
        push_req(OP_SAMPLE, S_MIN);
        push_req(OP_SAMPLE, -24'sd1);
        push_req(OP_SAMPLE, '0);
        push_req(OP_UNUSED, 24'sh5A5A5A);
        drain();

        // short ramp: fade out to silence, repeated requests, fade back in
        write_reg(CFG_RAMP_STEPS, 20'd2);
        push_req(OP_FADE_OUT, '0);
        push_req(OP_FADE_OUT, S_MAX);       // repeat while fading out
        push_req(OP_SAMPLE, S_MAX);
        push_req(OP_SAMPLE, S_MIN);         // gain reaches zero here
        push_req(OP_SAMPLE, -24'sd1);
        push_req(OP_FADE_OUT, '0);          // clears the done flag
        push_req(OP_SAMPLE, 24'sd1);        // flag sets again
        push_req(OP_FADE_IN, S_MIN);        // flag survives a fade-in
        push_req(OP_FADE_IN, '0);           // repeat does nothing
        push_req(OP_SAMPLE, S_MAX);
        push_req(OP_SAMPLE, S_MIN);
        push_req(OP_SAMPLE, 24'sd12345);
        drain();

        // zero ramp length: gain jumps at the request
        write_reg(CFG_RAMP_STEPS, '0);
        push_req(OP_FADE_OUT, '0);
        push_req(OP_SAMPLE, S_MAX);
        push_req(OP_FADE_IN, '0);
        push_req(OP_SAMPLE, S_MIN);
        drain();

        // disabled: pass-through, requests still move phase and target
        write_reg(CFG_ENABLED, '0);
        push_req(OP_SAMPLE, S_MIN);
        push_req(OP_FADE_OUT, '0);
        push_req(OP_SAMPLE, S_MAX);
        push_req(OP_FADE_IN, '0);
        drain();
        write_reg(CFG_ENABLED, 20'd1);
        write_reg(CFG_RAMP_STEPS, RAMP_MAX);
        push_req(OP_FADE_OUT, '0);
        push_req(OP_SAMPLE, S_MAX);
        drain();

        // random phases, each with its own register setting
        was_off = 1'b0;
        for (int p = 0; p < 16; p++) begin
            idle_on = (p < 13);
            case ($urandom_range(0, 4))
                0:       ramp = 1;
                1:       ramp = $urandom_range(2, 8);
                2:       ramp = $urandom_range(9, 40);
                3:       ramp = 480;
                default: ramp = RAMP_MAX;
            endcase
            write_reg(CFG_RAMP_STEPS, CFG_DATA_W'(ramp));
            if (p % 4 == 3) begin
                write_reg(CFG_ENABLED, '0);
                was_off = 1'b1;
            end else if (was_off || $urandom_range(0, 2) == 0) begin
                write_reg(CFG_ENABLED, 20'd1);
                was_off = 1'b0;
            end
            start_cnt = items_queued;
            paused    = 1'b0;
            while (items_queued - start_cnt < 78) begin
                queue_fade_cycle(ramp);
                // mid-phase hold-off: sender waits for every result
                if (p == 6 && !paused && items_queued - start_cnt >= 45) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
